// ===== rtl/core/pirl_pkg.sv =====
package pirl_pkg;

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 5;
    localparam int STAT_W  = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    localparam logic [FUNC_W-1:0] FN_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BOUNDS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // broadcast to every cell
    typedef struct packed {
        logic             insert;
        logic             remove;
        logic [POS_W-1:0] pos;
    } shift_cmd_t;

endpackage

// ===== rtl/core/pirl_cell.sv =====
module pirl_cell #(
    parameter int WORD_WIDTH = 32,
    parameter int INDEX_W    = 4,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  pirl_pkg::shift_cmd_t  cmd,
    input  logic [WORD_WIDTH-1:0] ins_word,
    input  logic [WORD_WIDTH-1:0] left_word,
    input  logic [WORD_WIDTH-1:0] right_word,
    output logic [WORD_WIDTH-1:0] word
);

    localparam int CMP_W = (INDEX_W > pirl_pkg::POS_W) ? INDEX_W : pirl_pkg::POS_W;

    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      idx_ext;
    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;

    assign pos_ext = CMP_W'(cmd.pos);
    assign idx_ext = CMP_W'(INDEX);

    always_comb begin
        word_next = word_reg;
        if (cmd.insert) begin
            if (idx_ext > pos_ext) begin
                word_next = left_word;
            end else if (idx_ext == pos_ext) begin
                word_next = ins_word;
            end
        end else if (cmd.remove) begin
            if (idx_ext >= pos_ext) begin
                word_next = right_word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== rtl/core/pirl_ctrl.sv =====
module pirl_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CNT_W    = 5
) (
    input  logic [pirl_pkg::FUNC_W-1:0] func,
    input  logic [pirl_pkg::POS_W-1:0]  position,
    input  logic [CNT_W-1:0]            count,
    output pirl_pkg::shift_cmd_t        cmd,
    output logic                        rd_ok,
    output logic [pirl_pkg::STAT_W-1:0] status,
    output logic [CNT_W-1:0]            count_next
);

    localparam int CMP_W = (CNT_W > pirl_pkg::POS_W) ? CNT_W : pirl_pkg::POS_W;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count);
    assign full    = (count == CNT_W'(CAPACITY));

    always_comb begin
        cmd.insert = 1'b0;
        cmd.remove = 1'b0;
        cmd.pos    = position;
        rd_ok      = 1'b0;
        status     = pirl_pkg::ST_OK;
        count_next = count;
        unique case (func)
            pirl_pkg::FN_READ: begin
                if (pos_ext >= cnt_ext) begin
                    status = pirl_pkg::ST_BOUNDS;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            pirl_pkg::FN_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status = pirl_pkg::ST_BOUNDS;
                end else if (full) begin
                    status = pirl_pkg::ST_FULL;
                end else begin
                    cmd.insert = 1'b1;
                    count_next = count + CNT_W'(1);
                end
            end
            pirl_pkg::FN_REMOVE: begin
                if (pos_ext >= cnt_ext) begin
                    status = pirl_pkg::ST_BOUNDS;
                end else begin
                    cmd.remove = 1'b1;
                    count_next = count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/positional_insert_remove_list.sv =====
// Positional insert/remove list: an ordered list of up to CAPACITY words.
// Input channel (s_*): one word per operation, read, insert before or
// remove at a position. Result channel (m_*): one word per operation with
// the element read (zero unless a good read), the length afterwards and a
// status (ok, position out of bounds, list full on insert).
// Storage is a row of cells, one per list entry; an insert or remove loads
// every affected cell from a neighbor or the new word in the same cycle.
// The result is registered and valid the cycle after the input word
// is taken. Throughput: one operation per cycle, limited only by the
// single output register; the next input is taken in the same cycle the
// held result is taken.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared and are never read before written.
// When the receiver holds m_tready low, the result stays in the output
// register and s_tready drops until it is taken.
module positional_insert_remove_list #(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func[1:0], position[6:2], value[38:7], zero fill
    input  logic [pirl_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_value[31:0], length[36:32], status[38:37], zero fill
    output logic [pirl_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [pirl_pkg::FUNC_W-1:0]  in_func;
    logic [pirl_pkg::POS_W-1:0]   in_pos;
    logic [pirl_pkg::VALUE_W-1:0] in_value;
    logic                         s_acc;

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    pirl_pkg::shift_cmd_t         ctrl_cmd;
    pirl_pkg::shift_cmd_t         cell_cmd;
    logic                         rd_ok;
    logic [pirl_pkg::STAT_W-1:0]  status;

    logic [WORD_WIDTH-1:0]        ins_word;
    logic [WORD_WIDTH-1:0]        cell_word [CAPACITY];
    logic [WORD_WIDTH-1:0]        rd_word;
    logic [IDX_W-1:0]             rd_idx;
    logic [pirl_pkg::VALUE_W-1:0] rd_value;

    logic                         m_tvalid_reg;
    logic                         m_tvalid_next;
    logic [pirl_pkg::M_TDATA_W-1:0] m_tdata_reg;

    assign in_func  = s_tdata[1:0];
    assign in_pos   = s_tdata[6:2];
    assign in_value = s_tdata[38:7];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    pirl_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .func       (in_func),
        .position   (in_pos),
        .count      (count_reg),
        .cmd        (ctrl_cmd),
        .rd_ok      (rd_ok),
        .status     (status),
        .count_next (count_next)
    );

    always_comb begin
        cell_cmd        = ctrl_cmd;
        cell_cmd.insert = ctrl_cmd.insert && s_acc;
        cell_cmd.remove = ctrl_cmd.remove && s_acc;
    end

    assign ins_word = WORD_WIDTH'(in_value);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_WIDTH-1:0] left_word;
        logic [WORD_WIDTH-1:0] right_word;

        if (i == 0) begin : g_first
            assign left_word = ins_word;
        end else begin : g_mid_l
            assign left_word = cell_word[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_word = cell_word[i];
        end else begin : g_mid_r
            assign right_word = cell_word[i+1];
        end

        pirl_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .INDEX_W    (IDX_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .ins_word   (ins_word),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (cell_word[i])
        );
    end

    // out-of-range index only when rd_ok is low
    assign rd_idx   = IDX_W'(in_pos);
    assign rd_word  = cell_word[rd_idx];
    assign rd_value = rd_ok ? pirl_pkg::VALUE_W'(rd_word) : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_acc) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_acc) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            m_tdata_reg <= {1'b0, status, pirl_pkg::LEN_W'(count_next), rd_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && ctrl_cmd.insert |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (status != pirl_pkg::ST_OK) |=> $stable(count_reg))
        else $error("rejected operation changed the length");

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cell_cmd.insert && cell_cmd.remove))
        else $error("insert and remove at once");

endmodule
